// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent assertions used by the block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/mlu_pkg.sv -----
// ----------------------------------------------------------------------------
// Momentum/LARS update package
// Shared constants, register map, configuration struct and helper functions.
// ----------------------------------------------------------------------------
package mlu_pkg;

  // Field and datapath widths.
  localparam int ValueWidth = 32;
  localparam int CoeffWidth = 32;
  localparam int SumWidth   = 64;
  localparam int RateWidth  = 48;
  localparam int ProdWidth  = 2 * (ValueWidth + 1);
  localparam int AddrWidth  = 5;

  // Action codes carried in tuser. The last code is unused and is dropped.
  localparam logic [1:0] ActAccum  = 2'd0;
  localparam logic [1:0] ActFinish = 2'd1;
  localparam logic [1:0] ActUpdate = 2'd2;
  localparam logic [1:0] ActUnused = 2'd3;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] RegLearnRate = 3'd0;
  localparam logic [2:0] RegMomentum  = 3'd1;
  localparam logic [2:0] RegNesterov  = 3'd2;
  localparam logic [2:0] RegLars      = 3'd3;
  localparam logic [2:0] RegTrust     = 3'd4;
  localparam logic [2:0] RegDecay     = 3'd5;

  // Reset values of the LARS coefficients (about 0.001 and 0.0005).
  localparam logic [CoeffWidth-1:0] TrustReset = 32'd4294967;
  localparam logic [CoeffWidth-1:0] DecayReset = 32'd2147484;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [CoeffWidth-1:0] learn_rate;
    logic [CoeffWidth-1:0] momentum_coeff;
    logic                  nesterov_on;
    logic                  lars_on;
    logic [CoeffWidth-1:0] trust_ratio;
    logic [CoeffWidth-1:0] decay_coeff;
  } cfg_t;

  // Saturate a wide signed value to the signed value range.
  function automatic logic [ValueWidth-1:0] sat_value(input logic [ProdWidth-1:0] x);
    logic [ValueWidth-1:0] res;
    if (x[ProdWidth-1:ValueWidth-1] == '0 || x[ProdWidth-1:ValueWidth-1] == '1) begin
      res = x[ValueWidth-1:0];
    end else if (x[ProdWidth-1]) begin
      res = {1'b1, {(ValueWidth-1){1'b0}}};
    end else begin
      res = {1'b0, {(ValueWidth-1){1'b1}}};
    end
    return res;
  endfunction

  // Unsigned add that sticks at all ones.
  function automatic logic [SumWidth-1:0] add_sat64(input logic [SumWidth-1:0] a,
                                                    input logic [SumWidth-1:0] b);
    logic [SumWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumWidth] ? '1 : s[SumWidth-1:0];
  endfunction

endpackage

// ----- rtl/mlu_sqrt.sv -----
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64-bit radicand, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module mlu_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  localparam int Steps = 32;
  localparam int CntWidth = $clog2(Steps);

  logic                busy_q;
  logic                done_q;
  logic [CntWidth-1:0] cnt_q;
  logic [63:0]         rad_q;
  logic [34:0]         rem_q;
  logic [31:0]         root_q;
  logic [34:0]         rem_sh;
  logic [34:0]         trial;
  logic                ge;

  // One digit step: bring down two bits and try the next root bit.
  assign rem_sh = {rem_q[32:0], rad_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntWidth'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- rtl/mlu_div.sv -----
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of a 64-bit dividend by a 33-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module mlu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  localparam int Steps = 64;
  localparam int CntWidth = $clog2(Steps);

  logic                busy_q;
  logic                done_q;
  logic [CntWidth-1:0] cnt_q;
  logic [63:0]         quo_q;
  logic [33:0]         rem_q;
  logic [32:0]         den_q;
  logic [33:0]         rem_sh;
  logic                ge;

  // Shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem_q[32:0], quo_q[63]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntWidth'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/mlu_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file holding the rates and mode bits of the update block.
// ----------------------------------------------------------------------------
module mlu_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mlu_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output mlu_pkg::cfg_t                cfg_o
);

  mlu_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_rate     <= '0;
      cfg_q.momentum_coeff <= '0;
      cfg_q.nesterov_on    <= 1'b0;
      cfg_q.lars_on        <= 1'b0;
      cfg_q.trust_ratio    <= mlu_pkg::TrustReset;
      cfg_q.decay_coeff    <= mlu_pkg::DecayReset;
    end else if (wr_en) begin
      unique case (idx)
        mlu_pkg::RegLearnRate: cfg_q.learn_rate     <= pwdata;
        mlu_pkg::RegMomentum:  cfg_q.momentum_coeff <= pwdata;
        mlu_pkg::RegNesterov:  cfg_q.nesterov_on    <= pwdata[0];
        mlu_pkg::RegLars:      cfg_q.lars_on        <= pwdata[0];
        mlu_pkg::RegTrust:     cfg_q.trust_ratio    <= pwdata;
        mlu_pkg::RegDecay:     cfg_q.decay_coeff    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read decoder.
  always_comb begin
    unique case (idx)
      mlu_pkg::RegLearnRate: prdata = cfg_q.learn_rate;
      mlu_pkg::RegMomentum:  prdata = cfg_q.momentum_coeff;
      mlu_pkg::RegNesterov:  prdata = {31'd0, cfg_q.nesterov_on};
      mlu_pkg::RegLars:      prdata = {31'd0, cfg_q.lars_on};
      mlu_pkg::RegTrust:     prdata = cfg_q.trust_ratio;
      mlu_pkg::RegDecay:     prdata = cfg_q.decay_coeff;
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/momentum_lars_update.sv -----
// ----------------------------------------------------------------------------
// Momentum optimizer step with LARS local rate
// Sequencer around one shared 33x33 multiplier, a square root and a divider.
// ----------------------------------------------------------------------------
// Usage: each word on the slave stream carries one parameter element with its
// gradient and velocity; tuser selects accumulate, finish or update. Update
// words produce one result word (new parameter and velocity) on the master
// stream; accumulate and finish words produce none. The user writes registers
// over the APB port while the block is idle; the block does not enforce this.
// Timing: the block takes one word at a time and drops tready while it works.
// Accumulate and update are set by the passes through the shared multiplier.
// Finish runs two 32-step square roots and one 64-step division; with LARS
// off or a zero norm the division is skipped. A finished result sits in an
// output register, so the next word is taken while it waits; if the receiver
// stalls, an update waits at its last step until the output register is free.
// Reset clears the norm sums, the local rate and all handshake state, and
// loads register defaults.
// ----------------------------------------------------------------------------
module momentum_lars_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave stream. tdata: param_value[31:0], grad_value[63:32],
  // velocity_value[95:64]. tuser: action[1:0].
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,
  input  logic [1:0]                    s_axis_tuser,
  // Master stream. tdata: new_param[31:0], new_velocity[63:32].
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlu_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int Vw = mlu_pkg::ValueWidth;
  localparam int Pw = mlu_pkg::ProdWidth;

  typedef enum logic [4:0] {
    S_IDLE, S_ACC_P, S_ACC_G, S_ACC_END,
    S_SQP, S_SQP_W, S_SQG, S_SQG_W, S_FIN_CHK, S_FIN_M2, S_FIN_M3, S_DIV, S_DIV_W,
    S_VEL, S_VSAT, S_MUL2, S_TERM, S_MUL3, S_PNEW, S_OUT
  } state_e;

  state_e        state_q;
  mlu_pkg::cfg_t cfg;

  logic [Vw-1:0]   p_q, g_q, v_q, vn_q, pnew_q;
  logic [63:0]     psum_q, gsum_q;
  logic [47:0]     lrate_q;
  logic [31:0]     pn_q, gn_q, a_q;
  logic [32:0]     den_q;
  logic [33:0]     tmp_q;
  logic signed [Pw-1:0] prod_q;
  logic signed [32:0]   mul_a, mul_b;
  logic signed [Pw-1:0] prod_sh, g_ext, p_ext, tmp_ext, diff;
  logic [47:0]     rate;
  logic            out_valid_q;
  logic [63:0]     out_data_q;
  logic            sq_start, sq_done, dv_start, dv_done;
  logic [63:0]     sq_rad, quo;
  logic [31:0]     sq_root;
  logic            s_fire;

  mlu_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  mlu_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i (sq_start), .radicand_i (sq_rad), .done_o (sq_done), .root_o (sq_root)
  );

  mlu_div u_div (
    .clk_i, .rst_ni,
    .start_i (dv_start), .dividend_i (prod_q[63:0]), .divisor_i (den_q),
    .done_o (dv_done), .quotient_o (quo)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign sq_start = (state_q == S_SQP) || (state_q == S_SQG);
  assign sq_rad   = (state_q == S_SQP) ? psum_q : gsum_q;
  assign dv_start = (state_q == S_DIV);

  // Floor shift of the product and sign-extended operands for the adders.
  assign prod_sh = prod_q >>> 32;
  assign g_ext   = {{(Pw-Vw){g_q[Vw-1]}}, g_q};
  assign p_ext   = {{(Pw-Vw){p_q[Vw-1]}}, p_q};
  assign tmp_ext = {{(Pw-34){tmp_q[33]}}, tmp_q};
  assign rate    = cfg.lars_on ? lrate_q : {16'd0, cfg.learn_rate};
  assign diff    = cfg.nesterov_on ? (p_ext - prod_sh) : (p_ext - (prod_q + tmp_ext));

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ACC_P: begin
        mul_a = {p_q[Vw-1], p_q};
        mul_b = {p_q[Vw-1], p_q};
      end
      S_ACC_G: begin
        mul_a = {g_q[Vw-1], g_q};
        mul_b = {g_q[Vw-1], g_q};
      end
      S_FIN_CHK: begin
        mul_a = {1'b0, cfg.learn_rate};
        mul_b = {1'b0, cfg.trust_ratio};
      end
      S_FIN_M2: begin
        mul_a = {1'b0, cfg.decay_coeff};
        mul_b = {1'b0, pn_q};
      end
      S_FIN_M3: begin
        mul_a = {1'b0, a_q};
        mul_b = {1'b0, pn_q};
      end
      S_VEL: begin
        mul_a = {1'b0, cfg.momentum_coeff};
        mul_b = {v_q[Vw-1], v_q};
      end
      S_MUL2: begin
        mul_a = cfg.nesterov_on ? {1'b0, cfg.momentum_coeff} : {1'b0, rate[31:0]};
        mul_b = {vn_q[Vw-1], vn_q};
      end
      S_MUL3: begin
        if (cfg.nesterov_on) begin
          mul_a = tmp_q[32:0];
          mul_b = {1'b0, cfg.learn_rate};
        end else begin
          mul_a = {17'd0, rate[47:32]};
          mul_b = {vn_q[Vw-1], vn_q};
        end
      end
      default: ;
    endcase
  end

  // Sequencer, state and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      psum_q      <= '0;
      gsum_q      <= '0;
      lrate_q     <= '0;
    end else begin
      prod_q <= mul_a * mul_b;
      // The output step below owns the valid flag while it runs.
      if (out_valid_q && m_axis_tready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            p_q <= s_axis_tdata[31:0];
            g_q <= s_axis_tdata[63:32];
            v_q <= s_axis_tdata[95:64];
            case (s_axis_tuser)
              mlu_pkg::ActAccum:  state_q <= S_ACC_P;
              mlu_pkg::ActFinish: state_q <= S_SQP;
              mlu_pkg::ActUpdate: state_q <= S_VEL;
              default:            state_q <= S_IDLE;
            endcase
          end
        end
        // Accumulate the squares into the saturating sums.
        S_ACC_P: state_q <= S_ACC_G;
        S_ACC_G: begin
          psum_q  <= mlu_pkg::add_sat64(psum_q, prod_q[63:0]);
          state_q <= S_ACC_END;
        end
        S_ACC_END: begin
          gsum_q  <= mlu_pkg::add_sat64(gsum_q, prod_q[63:0]);
          state_q <= S_IDLE;
        end
        // Finish: both norms, then the local rate.
        S_SQP: state_q <= S_SQP_W;
        S_SQP_W: begin
          if (sq_done) begin
            pn_q    <= sq_root;
            state_q <= S_SQG;
          end
        end
        S_SQG: state_q <= S_SQG_W;
        S_SQG_W: begin
          if (sq_done) begin
            gn_q    <= sq_root;
            state_q <= S_FIN_CHK;
          end
        end
        S_FIN_CHK: begin
          if (!cfg.lars_on || pn_q == '0 || gn_q == '0) begin
            lrate_q <= {16'd0, cfg.learn_rate};
            psum_q  <= '0;
            gsum_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_FIN_M2;
          end
        end
        S_FIN_M2: begin
          a_q     <= prod_q[63:32];
          state_q <= S_FIN_M3;
        end
        S_FIN_M3: begin
          den_q   <= {1'b0, gn_q} + {1'b0, prod_q[63:32]};
          state_q <= S_DIV;
        end
        S_DIV: state_q <= S_DIV_W;
        S_DIV_W: begin
          if (dv_done) begin
            lrate_q <= (quo[63:48] != '0) ? '1 : quo[47:0];
            psum_q  <= '0;
            gsum_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        // Update: velocity, then the parameter step.
        S_VEL: state_q <= S_VSAT;
        S_VSAT: begin
          vn_q    <= mlu_pkg::sat_value(prod_sh + g_ext);
          state_q <= S_MUL2;
        end
        S_MUL2: state_q <= S_TERM;
        S_TERM: begin
          if (cfg.nesterov_on) begin
            tmp_q <= {{2{1'b0}}, 32'd0} | 34'(signed'(mlu_pkg::sat_value(g_ext + prod_sh)));
          end else begin
            tmp_q <= prod_sh[33:0];
          end
          state_q <= S_MUL3;
        end
        S_MUL3: state_q <= S_PNEW;
        S_PNEW: begin
          pnew_q  <= mlu_pkg::sat_value(diff);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {vn_q, pnew_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mlu_checker.sv -----
// ----------------------------------------------------------------------------
// Port checker
// Concurrent checks on the stream and configuration ports of the block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlu_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        pready
);

  // The register port never stalls.
  `ASSERT_ALWAYS(a_pready, clk_i, rst_ni, pready)

  // A waiting result stays offered with its data.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata))

  // The sequencer is busy right after it takes a known action.
  `ASSERT_NEXT(a_busy, clk_i, rst_ni,
               s_axis_tvalid && s_axis_tready && s_axis_tuser != mlu_pkg::ActUnused,
               !s_axis_tready)

  // Accumulate and finish words never raise a result.
  `ASSERT_NEXT(a_no_result, clk_i, rst_ni,
               s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
               (s_axis_tuser == mlu_pkg::ActAccum || s_axis_tuser == mlu_pkg::ActFinish),
               !m_axis_tvalid)

endmodule

bind momentum_lars_update mlu_port_checker u_checker (.*);

// ----- tb/sv/mlu_checker.sv -----
// ----------------------------------------------------------------------------
// Momentum/LARS update checker
// Watches both streams, predicts each result word from the accepted input
// words and the register writes, and compares it field by field.
// ----------------------------------------------------------------------------
module mlu_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o,
  output int          update_count_o,
  output int          finish_count_o
);

  // Predictor copy of the registers and the norm state.
  logic [31:0] lr_q, mu_q, trust_q, decay_q;
  logic        nest_q, lars_q;
  logic [63:0] psum_q, gsum_q;
  logic [47:0] rate_q;

  // Expected result words, oldest first: {new_velocity, new_param}.
  logic [63:0] expected_words[$];

  function automatic longint floor_q32(input longint x);
    return x >>> 32;
  endfunction

  function automatic longint clamp_value(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    fail_count_o++;
  endtask

  // Apply one accepted input word to the predictor.
  task automatic predict_word(input logic [1:0] act, input logic [95:0] d);
    longint p, g, v, vn, t, pnew, rh, rl;
    logic [63:0] pm, gm, pn, gn, a, num, den, q, rate;
    p = longint'(signed'(d[31:0]));
    g = longint'(signed'(d[63:32]));
    v = longint'(signed'(d[95:64]));
    case (act)
      mlu_pkg::ActAccum: begin
        pm = (p < 0) ? -p : p;
        gm = (g < 0) ? -g : g;
        psum_q = sat_add(psum_q, pm * pm);
        gsum_q = sat_add(gsum_q, gm * gm);
      end
      mlu_pkg::ActFinish: begin
        pn = int_sqrt(psum_q);
        gn = int_sqrt(gsum_q);
        if (lars_q && pn != 0 && gn != 0) begin
          a = (64'(lr_q) * 64'(trust_q)) >> 32;
          num = a * pn;
          den = gn + ((64'(decay_q) * pn) >> 32);
          q = num / den;
          rate_q = (q > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
        end else begin
          rate_q = 48'(lr_q);
        end
        psum_q = 0;
        gsum_q = 0;
        finish_count_o++;
      end
      mlu_pkg::ActUpdate: begin
        vn = clamp_value(floor_q32(longint'(mu_q) * v) + g);
        if (nest_q) begin
          t = clamp_value(g + floor_q32(longint'(mu_q) * vn));
          pnew = p - floor_q32(t * longint'(lr_q));
        end else begin
          rate = lars_q ? 64'(rate_q) : 64'(lr_q);
          rh = longint'(rate >> 32);
          rl = longint'(rate & 64'hFFFF_FFFF);
          pnew = p - (rh * vn + floor_q32(rl * vn));
        end
        pnew = clamp_value(pnew);
        expected_words.push_back({vn[31:0], pnew[31:0]});
        update_count_o++;
      end
      default: ;
    endcase
  endtask

  // Sample both channels and the register port at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= 0; mu_q <= 0; nest_q <= 0; lars_q <= 0;
      trust_q <= mlu_pkg::TrustReset; decay_q <= mlu_pkg::DecayReset;
      psum_q <= 0; gsum_q <= 0; rate_q <= 0;
      expected_words.delete();
      fail_count_o <= 0;
      update_count_o <= 0;
      finish_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          mlu_pkg::RegLearnRate: lr_q = pwdata;
          mlu_pkg::RegMomentum:  mu_q = pwdata;
          mlu_pkg::RegNesterov:  nest_q = pwdata[0];
          mlu_pkg::RegLars:      lars_q = pwdata[0];
          mlu_pkg::RegTrust:     trust_q = pwdata;
          mlu_pkg::RegDecay:     decay_q = pwdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", m_axis_tdata, 64'd0);
        end else begin
          if (m_axis_tdata[31:0] !== expected_words[0][31:0])
            report("new_param", 64'(m_axis_tdata[31:0]), 64'(expected_words[0][31:0]));
          if (m_axis_tdata[63:32] !== expected_words[0][63:32])
            report("new_velocity", 64'(m_axis_tdata[63:32]),
                   64'(expected_words[0][63:32]));
          void'(expected_words.pop_front());
        end
      end
    end
  end

  assign pending_o = expected_words.size();

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Momentum/LARS update testbench
// Drives directed and random words through the block under several register
// settings with random idling on both streams; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = mlu_pkg::ActAccum;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, update_count, finish_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int cfg_phases = 0;

  momentum_lars_update i_dut (.*);

  mlu_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .psel, .penable, .pwrite,
    .paddr, .pwdata, .pready, .fail_count_o(fail_count), .pending_o(pending),
    .update_count_o(update_count), .finish_count_o(finish_count)
  );

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Wait until every result has come, then out-wait a finish in flight.
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Offer one word and hold it until accepted.
  task automatic send_word(input logic [1:0] act, input logic [31:0] p,
                           input logic [31:0] g, input logic [31:0] v);
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {v, g, p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(2) - 1;
      3: return 32'(signed'($urandom_range(400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(4))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config(input bit extreme);
    reg_write(mlu_pkg::RegLearnRate, extreme ? 32'hFFFF_FFFF : pick_coeff());
    reg_write(mlu_pkg::RegMomentum, extreme ? 32'hFFFF_FFFF : pick_coeff());
    reg_write(mlu_pkg::RegNesterov, $urandom_range(1));
    reg_write(mlu_pkg::RegLars, $urandom_range(1));
    reg_write(mlu_pkg::RegTrust, extreme ? 32'hFFFF_FFFF : pick_coeff());
    reg_write(mlu_pkg::RegDecay, extreme ? 32'd0 : pick_coeff());
    cfg_phases++;
  endtask

  // A run of accumulates, a finish, then updates; occasionally noise.
  task automatic random_batch();
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++)
      send_word($urandom_range(9) == 0 ? mlu_pkg::ActFinish : mlu_pkg::ActAccum,
                pick_value(), pick_value(), pick_value());
    send_word(mlu_pkg::ActFinish, $urandom, $urandom, $urandom);
    n = $urandom_range(12, 2);
    for (int i = 0; i < n; i++)
      send_word($urandom_range(19) == 0 ? mlu_pkg::ActUnused : mlu_pkg::ActUpdate,
                pick_value(), pick_value(), pick_value());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: updates before any finish, extremes, unused code, zero norms.
    send_word(mlu_pkg::ActUpdate, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
    drain();
    reg_write(mlu_pkg::RegLars, 1);
    send_word(mlu_pkg::ActUpdate, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_word(mlu_pkg::ActFinish, 32'd0, 32'd0, 32'd0);
    send_word(mlu_pkg::ActUpdate, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    random_config(1'b1);
    reg_write(mlu_pkg::RegLars, 1);
    reg_write(mlu_pkg::RegNesterov, 0);
    for (int i = 0; i < 3; i++)
      send_word(mlu_pkg::ActAccum, 32'h8000_0000, 32'h8000_0000, 32'd0);
    send_word(mlu_pkg::ActFinish, 32'd0, 32'd0, 32'd0);
    send_word(mlu_pkg::ActUpdate, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(mlu_pkg::ActAccum, 32'h0001_0000, 32'd0, 32'd0);
    send_word(mlu_pkg::ActFinish, 32'd0, 32'd0, 32'd0);
    send_word(mlu_pkg::ActUpdate, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF);
    send_word(mlu_pkg::ActUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(mlu_pkg::ActAccum, 32'h0000_0100, 32'h0000_0200, 32'd0);
    send_word(mlu_pkg::ActFinish, 32'd0, 32'd0, 32'd0);
    send_word(mlu_pkg::ActUpdate, 32'h0001_0000, 32'h0000_0100, 32'h0000_1000);
    drain();
    reg_write(mlu_pkg::RegNesterov, 1);
    send_word(mlu_pkg::ActUpdate, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_word(mlu_pkg::ActUpdate, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();

    // Random phases across idling regimes with register changes between them.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 79 : 0;
      recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 21 : 0;
      for (int k = 0; k < 6; k++) begin
        drain();
        random_config(k == 0 && ph == 2);
        if (k == 3) hold_cycles = 400;
        for (int b = 0; b < 7; b++) random_batch();
      end
    end

    drain();
    $display("covered %0d update results, %0d finishes, %0d register settings",
             update_count, finish_count, cfg_phases);
    $display("with sender and receiver idling swapped between phases and long stalls");
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- momentum_lars_update.f -----
+incdir+rtl
rtl/mlu_pkg.sv
rtl/mlu_sqrt.sv
rtl/mlu_div.sv
rtl/mlu_regs.sv
rtl/momentum_lars_update.sv
rtl/mlu_checker.sv
tb/sv/mlu_checker.sv
tb/sv/tb_top.sv
